/* rtl/fdsc_pkg.sv */
// Shared types and constants for the frame deframer with sum checksum.
`default_nettype none
package fdsc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LeftWidth  = 9;
   localparam int unsigned PhaseWidth = 3;

   localparam logic [ByteWidth-1:0] START_CMD  = 8'h01;
   localparam logic [ByteWidth-1:0] START_DATA = 8'h02;

   localparam logic [PhaseWidth-1:0] PH_HUNT    = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_LENGTH  = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_PAYLOAD = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_CHECK   = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_TRAILER = 3'd4;

   localparam logic [LeftWidth-1:0] FULL_FRAME = 9'd256;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 frame_kind;
      logic                 checksum_ok;
      logic                 last;
   } fdsc_result_type;

endpackage
`default_nettype wire

/* rtl/frame_deframer_sum_checksum_top.sv */
// Top level of the frame deframer: input register, decoder and result register.
// Takes one received byte per cycle and hunts for 0x01 (command/status) or 0x02 (data),
// then reads a length byte (0 means 256), passes each payload byte out, adds in a
// checksum byte and ends with a request that carries the trailer byte, tlast and the
// checksum verdict. Sustained rate is one byte per clock, and only back-pressure on rsp
// slows acceptance; a byte accepted on req reaches rsp through the input register, then
// the result register. Start, length and checksum bytes yield no request.
`default_nettype none
module frame_deframer_sum_checksum_top
   import fdsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,   // [7:0] rx_byte
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ByteWidth-1:0]      rsp_tdata,   // [7:0] data
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser    // [0] frame_kind, [1] checksum_ok
);

   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 take;
   logic                 res_valid;
   logic                 out_free;
   fdsc_result_type      res;

   assign take       = in_valid_ff && (!res_valid || out_free);
   assign req_tready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   fdsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (in_byte_ff),
      .res       (res),
      .res_valid (res_valid)
   );

   fdsc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      take && res_valid |=> rsp_tvalid)
      else $error("decoded request lost before the output");

endmodule
`default_nettype wire

/* rtl/fdsc_core.sv */
// Frame phase tracking, length count and running sum; decodes one byte per cycle while take is high.
`default_nettype none
module fdsc_core
   import fdsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [ByteWidth-1:0] rx_byte,
   output fdsc_result_type           res,
   output logic                      res_valid
);

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic                  kind_ff, kind_in;
   logic [LeftWidth-1:0]  left_ff, left_in, left_dec;
   logic [ByteWidth-1:0]  sum_ff, sum_in, sum_add;

   assign sum_add  = sum_ff + rx_byte;
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      left_in         = left_ff;
      sum_in          = sum_ff;
      res_valid       = 1'b0;
      res.data        = rx_byte;
      res.frame_kind  = kind_ff;
      res.checksum_ok = 1'b0;
      res.last        = 1'b0;
      unique case (phase_ff)
         PH_LENGTH: begin
            sum_in   = rx_byte;
            left_in  = (rx_byte == '0) ? FULL_FRAME : {1'b0, rx_byte};
            phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_in    = sum_add;
            res_valid = 1'b1;
            left_in   = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            sum_in   = sum_add;
            phase_in = PH_TRAILER;
         end
         PH_TRAILER: begin
            res_valid       = 1'b1;
            res.checksum_ok = (sum_ff == '0);
            res.last        = 1'b1;
            phase_in        = PH_HUNT;
         end
         default: begin
            // hunting; stray phase codes land here too
            if (rx_byte == START_CMD || rx_byte == START_DATA) begin
               kind_in  = (rx_byte == START_DATA);
               phase_in = PH_LENGTH;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         kind_ff  <= 1'b0;
         left_ff  <= '0;
         sum_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
      end
   end

   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with zero bytes left");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      left_ff <= FULL_FRAME)
      else $error("byte count beyond full frame");

   a_last_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      take && res_valid && res.last |=> phase_ff == PH_HUNT)
      else $error("trailer not followed by hunting");

   a_check_after_payload: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_PAYLOAD && left_ff == 9'd1 |=> phase_ff == PH_CHECK)
      else $error("final payload byte did not move to checksum");

endmodule
`default_nettype wire

/* rtl/fdsc_out_reg.sv */
// Result register that drives the response stream.
`default_nettype none
module fdsc_out_reg
   import fdsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire fdsc_result_type      res,
   output logic                      out_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ByteWidth-1:0]      rsp_tdata,
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser
);

   logic            valid_ff;
   fdsc_result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_free) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.data;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tuser  = {res_ff.checksum_ok, res_ff.frame_kind};

   a_ok_only_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !res_ff.last |-> !res_ff.checksum_ok)
      else $error("checksum flag set on a payload request");

endmodule
`default_nettype wire
